FILE: design/rpe_pkg.sv
`timescale 1ns / 1ps

package rpe_pkg;

   localparam int DATA_W         = 32;
   localparam int DEF_MAX_PARAMS = 8;
   localparam int DEF_FRAC_BITS  = 16;

   // stream and register port widths
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 136;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_PARAMS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INITIAL_COV   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FORGETTING    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_DEN       = 3'd3;

   localparam logic KIND_ELEMENT = 1'b0;
   localparam logic KIND_RESET   = 1'b1;

   localparam logic STATUS_APPLIED  = 1'b0;
   localparam logic STATUS_REJECTED = 1'b1;

   typedef logic signed [DATA_W-1:0] q_type;

   typedef struct packed {
      logic  start;
      q_type num;
      q_type den;
   } div_req_type;

   typedef struct packed {
      logic  done;
      q_type quot;
   } div_rsp_type;

   localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

   function automatic q_type sat32(input logic signed [63:0] v);
      q_type r;
      if (v > SAT_HI) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_LO) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: design/rpe_divider.sv
`timescale 1ns / 1ps

module rpe_divider #(
   parameter int FRAC_BITS = rpe_pkg::DEF_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rpe_pkg::div_req_type div_req,
   output rpe_pkg::div_rsp_type div_rsp
);
   import rpe_pkg::*;

   // sat32((num * 2^FRAC_BITS) / den), truncated toward zero, one bit a cycle
   localparam int DIV_W = DATA_W + FRAC_BITS;
   localparam int CNT_W = $clog2(DIV_W + 1);
   localparam logic [DIV_W-1:0] POS_LIMIT = DIV_W'(32'h7FFF_FFFF);
   localparam logic [DIV_W-1:0] NEG_LIMIT = DIV_W'(32'h8000_0000);

   logic              busy_ff, busy_in;
   logic              fin_ff, fin_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DATA_W:0]   rem_ff, rem_in;
   logic [DATA_W:0]   rem_sh;
   logic [DATA_W-1:0] dvs_ff, dvs_in;
   logic [DATA_W-1:0] num_mag, den_mag;
   q_type             quot_ff, quot_in;

   always_comb begin
      num_mag = div_req.num[DATA_W-1] ? unsigned'(-div_req.num) : unsigned'(div_req.num);
      den_mag = div_req.den[DATA_W-1] ? unsigned'(-div_req.den) : unsigned'(div_req.den);
      rem_sh  = {rem_ff[DATA_W-1:0], dvd_ff[DIV_W-1]};
      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quot_in = quot_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         dvd_in  = {num_mag, {FRAC_BITS{1'b0}}};
         dvs_in  = den_mag;
         rem_in  = '0;
         quo_in  = '0;
         neg_in  = div_req.num[DATA_W-1] ^ div_req.den[DATA_W-1];
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = rem_sh - {1'b0, dvs_ff};
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end
      // apply sign and clamp to 32 bits
      if (fin_ff) begin
         done_in = 1'b1;
         if (!neg_ff) begin
            quot_in = (quo_ff > POS_LIMIT) ? 32'sh7FFF_FFFF : q_type'(quo_ff[DATA_W-1:0]);
         end else begin
            quot_in = (quo_ff > NEG_LIMIT) ? 32'sh8000_0000 :
                      q_type'(-$signed(quo_ff[DATA_W-1:0]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      neg_ff  <= neg_in;
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

FILE: design/rls_parameter_estimator_core.sv
`timescale 1ns / 1ps
// Element word without the last mark: accepted while idle, no result.
// Last element: runs the update (gain and covariance steps skipped on a rejected update)
// on one shared multiplier and the one-bit-a-cycle divider that serves every gain and
// every covariance entry; then n result words, one a cycle while the receiver is ready.
// Reset (synchronous, active high) restores the default registers, zeroes the parameters
// and marks every covariance word invalid at once; no clearing pass is needed.

module rls_parameter_estimator_core #(
   parameter int MAX_PARAMS = rpe_pkg::DEF_MAX_PARAMS,
   parameter int FRAC_BITS  = rpe_pkg::DEF_FRAC_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // regressor_value[31:0], measurement[63:32]
   input  logic [rpe_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind
   input  logic                             req_tuser,
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // param_index[2:0], param_value[34:3], prediction[66:35], pred_error[98:67],
   // update_total[130:99], zero fill above
   output logic [rpe_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status
   output logic                             rsp_tuser,
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rpe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rpe_pkg::CSR_DATA_W-1:0]   csr_data
);
   import rpe_pkg::*;

   localparam int IDX_W  = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
   localparam int CNT_W  = $clog2(MAX_PARAMS + 1);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;
   localparam logic [31:0] LAMBDA_ONE = 32'(64'd1 << FRAC_BITS);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_PRED  = 4'd1;
   localparam logic [3:0] S_ERR   = 4'd2;
   localparam logic [3:0] S_PPHI  = 4'd3;
   localparam logic [3:0] S_DEN   = 4'd4;
   localparam logic [3:0] S_CHECK = 4'd5;
   localparam logic [3:0] S_GAIN  = 4'd6;
   localparam logic [3:0] S_PHIP  = 4'd7;
   localparam logic [3:0] S_PUPD  = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   localparam logic [1:0] SUB_0 = 2'd0;
   localparam logic [1:0] SUB_1 = 2'd1;
   localparam logic [1:0] SUB_2 = 2'd2;
   localparam logic [1:0] SUB_3 = 2'd3;

   // control
   logic [3:0]        state_ff, state_in;
   logic [1:0]        sub_ff, sub_in;
   logic [IDX_W-1:0]  row_ff, row_in, col_ff, col_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [31:0]       upd_ff, upd_in;
   logic              status_ff, status_in;

   // configuration
   logic [3:0]        act_ff, act_in;
   logic [30:0]       icov_ff, icov_in;
   logic [16:0]       lam_ff, lam_in;
   logic [30:0]       mind_ff, mind_in;

   // datapath
   logic signed [63:0] acc_ff, acc_in, acc_sum;
   logic signed [63:0] prod_ff, prod_in, mul_full;
   q_type              meas_ff, meas_in, pred_ff, pred_in, err_ff, err_in, den_ff, den_in;
   q_type              phi_ff [MAX_PARAMS];
   q_type              phi_in [MAX_PARAMS];
   q_type              theta_ff [MAX_PARAMS];
   q_type              theta_in [MAX_PARAMS];
   q_type              pphi_ff [MAX_PARAMS];
   q_type              pphi_in [MAX_PARAMS];
   q_type              phip_ff [MAX_PARAMS];
   q_type              phip_in [MAX_PARAMS];
   q_type              gain_ff [MAX_PARAMS];
   q_type              gain_in [MAX_PARAMS];

   // covariance store: one word per entry, invalid words read as the reset value
   q_type              cov_mem [DEPTH];
   logic               cov_vld_ff [DEPTH];
   logic               cov_vld_in [DEPTH];
   q_type              rd_data_ff;
   logic               rd_vld_ff, rd_vld_in, rd_diag_ff, rd_diag_in;
   logic               mem_re, mem_we;
   logic [ADDR_W-1:0]  mem_addr;
   q_type              mem_wdata;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_idx_ff, rsp_idx_in;
   q_type              rsp_val_ff, rsp_val_in, rsp_pred_ff, rsp_pred_in;
   q_type              rsp_err_ff, rsp_err_in;
   logic               rsp_stat_ff, rsp_stat_in, rsp_last_ff, rsp_last_in;
   logic [31:0]        rsp_upd_ff, rsp_upd_in;

   // helpers
   logic [CNT_W-1:0]   n_w;
   logic [IDX_W-1:0]   last_w, phi_idx;
   q_type              lam_w, p_val, phi_sel, mul_a, mul_b, d_w;
   logic [30:0]        mind_w;
   logic [32:0]        den_abs;
   logic               req_acc, csr_acc, csr_hit, clear_w;
   logic               row_end, col_end;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   rpe_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = (state_ff == S_IDLE) && !req_tvalid;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_acc    = csr_valid && csr_ready;

   // clamp registers to their legal ranges
   always_comb begin
      if (act_ff == 4'd0) begin
         n_w = CNT_W'(1);
      end else if (int'(act_ff) > MAX_PARAMS) begin
         n_w = CNT_W'(MAX_PARAMS);
      end else begin
         n_w = CNT_W'(act_ff);
      end
      last_w = IDX_W'(n_w - 1'b1);
      if (lam_ff == 17'd0) begin
         lam_w = 32'sd1;
      end else if ({15'd0, lam_ff} > LAMBDA_ONE) begin
         lam_w = q_type'(LAMBDA_ONE);
      end else begin
         lam_w = q_type'({15'd0, lam_ff});
      end
      mind_w  = (mind_ff == 31'd0) ? 31'd1 : mind_ff;
      den_abs = den_ff[DATA_W-1] ? -(33'(den_ff)) : 33'(den_ff);
   end

   assign row_end  = (row_ff == last_w);
   assign col_end  = (col_ff == last_w);
   assign mem_addr = {row_ff, col_ff};
   assign p_val    = rd_vld_ff ? rd_data_ff : (rd_diag_ff ? q_type'({1'b0, icov_ff}) : '0);
   assign phi_idx  = (state_ff == S_PPHI) ? col_ff : row_ff;
   assign phi_sel  = phi_ff[phi_idx];
   assign acc_sum  = acc_ff + prod_ff;
   assign d_w      = sat32(64'(p_val) - prod_ff);

   // shared multiplier: operands picked by the step in progress
   always_comb begin
      unique case (state_ff)
         S_PRED: begin
            mul_a = theta_ff[row_ff];
            mul_b = phi_sel;
         end
         S_PPHI: begin
            mul_a = p_val;
            mul_b = phi_sel;
         end
         S_DEN: begin
            mul_a = phi_sel;
            mul_b = pphi_ff[row_ff];
         end
         S_GAIN: begin
            mul_a = gain_ff[row_ff];
            mul_b = err_ff;
         end
         S_PHIP: begin
            mul_a = phi_sel;
            mul_b = p_val;
         end
         S_PUPD: begin
            mul_a = gain_ff[row_ff];
            mul_b = phip_ff[col_ff];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_full = mul_a * mul_b;
      // arithmetic shift rounds toward minus infinity
      prod_in  = mul_full >>> FRAC_BITS;
   end

   always_comb begin
      state_in    = state_ff;
      sub_in      = sub_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      cnt_in      = cnt_ff;
      upd_in      = upd_ff;
      status_in   = status_ff;
      act_in      = act_ff;
      icov_in     = icov_ff;
      lam_in      = lam_ff;
      mind_in     = mind_ff;
      acc_in      = acc_ff;
      meas_in     = meas_ff;
      pred_in     = pred_ff;
      err_in      = err_ff;
      den_in      = den_ff;
      phi_in      = phi_ff;
      theta_in    = theta_ff;
      pphi_in     = pphi_ff;
      phip_in     = phip_ff;
      gain_in     = gain_ff;
      cov_vld_in  = cov_vld_ff;
      rd_vld_in   = rd_vld_ff;
      rd_diag_in  = rd_diag_ff;
      mem_re      = 1'b0;
      mem_we      = 1'b0;
      mem_wdata   = div_rsp.quot;
      div_req     = '0;
      csr_hit     = 1'b0;
      clear_w     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_idx_in  = rsp_idx_ff;
      rsp_val_in  = rsp_val_ff;
      rsp_pred_in = rsp_pred_ff;
      rsp_err_in  = rsp_err_ff;
      rsp_stat_in = rsp_stat_ff;
      rsp_upd_in  = rsp_upd_ff;
      rsp_last_in = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_tuser == KIND_RESET) begin
                  clear_w = 1'b1;
               end else begin
                  // store the element while there is room, drop extras
                  if (cnt_ff < n_w) begin
                     phi_in[cnt_ff[IDX_W-1:0]] = q_type'(req_tdata[31:0]);
                     cnt_in = cnt_ff + 1'b1;
                  end
                  if (req_tlast) begin
                     meas_in   = q_type'(req_tdata[63:32]);
                     state_in  = S_PRED;
                     sub_in    = SUB_0;
                     row_in    = '0;
                     col_in    = '0;
                     acc_in    = '0;
                     status_in = STATUS_APPLIED;
                  end
               end
            end else if (csr_acc) begin
               unique case (csr_index)
                  REG_ACTIVE_PARAMS: begin
                     act_in  = csr_data[3:0];
                     csr_hit = 1'b1;
                  end
                  REG_INITIAL_COV: begin
                     icov_in = csr_data[30:0];
                     csr_hit = 1'b1;
                  end
                  REG_FORGETTING: begin
                     lam_in  = csr_data[16:0];
                     csr_hit = 1'b1;
                  end
                  REG_MIN_DEN: begin
                     mind_in = csr_data[30:0];
                     csr_hit = 1'b1;
                  end
                  default: begin
                     csr_hit = 1'b0;
                  end
               endcase
               clear_w = csr_hit;
            end
         end

         S_PRED, S_PPHI, S_DEN, S_PHIP: begin
            case (sub_ff)
               SUB_0: begin
                  mem_re     = (state_ff == S_PPHI) || (state_ff == S_PHIP);
                  rd_vld_in  = cov_vld_ff[mem_addr];
                  rd_diag_in = (row_ff == col_ff);
                  sub_in     = SUB_1;
               end
               SUB_1: begin
                  sub_in = SUB_2;
               end
               default: begin
                  sub_in = SUB_0;
                  acc_in = acc_sum;
                  if (state_ff == S_PRED) begin
                     if (row_end) begin
                        pred_in  = sat32(acc_sum);
                        state_in = S_ERR;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end else if (state_ff == S_PPHI) begin
                     // row of P times phi
                     if (col_end) begin
                        pphi_in[row_ff] = sat32(acc_sum);
                        acc_in = '0;
                        col_in = '0;
                        if (row_end) begin
                           row_in   = '0;
                           acc_in   = 64'(lam_w);
                           state_in = S_DEN;
                        end else begin
                           row_in = row_ff + 1'b1;
                        end
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end else if (state_ff == S_DEN) begin
                     if (row_end) begin
                        den_in   = sat32(acc_sum);
                        state_in = S_CHECK;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end else begin
                     // phi' times a column of P
                     if (row_end) begin
                        phip_in[col_ff] = sat32(acc_sum);
                        acc_in = '0;
                        row_in = '0;
                        if (col_end) begin
                           col_in   = '0;
                           state_in = S_PUPD;
                        end else begin
                           col_in = col_ff + 1'b1;
                        end
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end
               end
            endcase
         end

         S_ERR: begin
            err_in   = sat32(64'(meas_ff) - 64'(pred_ff));
            state_in = S_PPHI;
            sub_in   = SUB_0;
            row_in   = '0;
            col_in   = '0;
            acc_in   = '0;
         end

         S_CHECK: begin
            row_in = '0;
            sub_in = SUB_0;
            if (den_abs < {2'b00, mind_w}) begin
               status_in = STATUS_REJECTED;
               state_in  = S_OUT;
            end else begin
               state_in = S_GAIN;
            end
         end

         S_GAIN: begin
            case (sub_ff)
               SUB_0: begin
                  div_req.start = 1'b1;
                  div_req.num   = pphi_ff[row_ff];
                  div_req.den   = den_ff;
                  sub_in        = SUB_1;
               end
               SUB_1: begin
                  if (div_rsp.done) begin
                     gain_in[row_ff] = div_rsp.quot;
                     sub_in = SUB_2;
                  end
               end
               SUB_2: begin
                  sub_in = SUB_3;
               end
               default: begin
                  theta_in[row_ff] = sat32(64'(theta_ff[row_ff]) + prod_ff);
                  sub_in = SUB_0;
                  if (row_end) begin
                     row_in   = '0;
                     col_in   = '0;
                     acc_in   = '0;
                     state_in = S_PHIP;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end
            endcase
         end

         S_PUPD: begin
            case (sub_ff)
               SUB_0: begin
                  mem_re     = 1'b1;
                  rd_vld_in  = cov_vld_ff[mem_addr];
                  rd_diag_in = (row_ff == col_ff);
                  sub_in     = SUB_1;
               end
               SUB_1: begin
                  sub_in = SUB_2;
               end
               SUB_2: begin
                  div_req.start = 1'b1;
                  div_req.num   = d_w;
                  div_req.den   = lam_w;
                  sub_in        = SUB_3;
               end
               default: begin
                  if (div_rsp.done) begin
                     mem_we               = 1'b1;
                     cov_vld_in[mem_addr] = 1'b1;
                     sub_in               = SUB_0;
                     if (col_end) begin
                        col_in = '0;
                        if (row_end) begin
                           row_in   = '0;
                           upd_in   = upd_ff + 32'd1;
                           state_in = S_OUT;
                        end else begin
                           row_in = row_ff + 1'b1;
                        end
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
               end
            endcase
         end

         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = 3'(row_ff);
               rsp_val_in   = theta_ff[row_ff];
               rsp_pred_in  = pred_ff;
               rsp_err_in   = err_ff;
               rsp_stat_in  = status_ff;
               rsp_upd_in   = upd_ff;
               rsp_last_in  = row_end;
               if (row_end) begin
                  // drop the buffered regressor for the next run
                  phi_in   = '{default: '0};
                  cnt_in   = '0;
                  row_in   = '0;
                  state_in = S_IDLE;
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // estimator reset: zero theta, buffer and update count, restore P to its initial diagonal
      if (clear_w) begin
         theta_in   = '{default: '0};
         phi_in     = '{default: '0};
         cov_vld_in = '{default: 1'b0};
         cnt_in     = '0;
         upd_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sub_ff       <= SUB_0;
         row_ff       <= '0;
         col_ff       <= '0;
         cnt_ff       <= '0;
         upd_ff       <= '0;
         status_ff    <= STATUS_APPLIED;
         act_ff       <= 4'd8;
         icov_ff      <= 31'd6553600;
         lam_ff       <= 17'd65536;
         mind_ff      <= 31'd1;
         phi_ff       <= '{default: '0};
         theta_ff     <= '{default: '0};
         cov_vld_ff   <= '{default: 1'b0};
         rd_vld_ff    <= 1'b0;
         rd_diag_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sub_ff       <= sub_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         cnt_ff       <= cnt_in;
         upd_ff       <= upd_in;
         status_ff    <= status_in;
         act_ff       <= act_in;
         icov_ff      <= icov_in;
         lam_ff       <= lam_in;
         mind_ff      <= mind_in;
         phi_ff       <= phi_in;
         theta_ff     <= theta_in;
         cov_vld_ff   <= cov_vld_in;
         rd_vld_ff    <= rd_vld_in;
         rd_diag_ff   <= rd_diag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff      <= acc_in;
      prod_ff     <= prod_in;
      meas_ff     <= meas_in;
      pred_ff     <= pred_in;
      err_ff      <= err_in;
      den_ff      <= den_in;
      pphi_ff     <= pphi_in;
      phip_ff     <= phip_in;
      gain_ff     <= gain_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_pred_ff <= rsp_pred_in;
      rsp_err_ff  <= rsp_err_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_upd_ff  <= rsp_upd_in;
      rsp_last_ff <= rsp_last_in;
   end

   // covariance memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cov_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= cov_mem[mem_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_upd_ff, rsp_err_ff, rsp_pred_ff, rsp_val_ff, rsp_idx_ff};
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_div_done_owned: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_GAIN || state_ff == S_PUPD))
      else $error("divider finished outside a gain or covariance step");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= n_w)
      else $error("element count passed the active parameter count");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == S_OUT)
      else $error("result word raised outside the output phase");

   a_upd_step: assert property (@(posedge clock) disable iff (reset)
      (upd_ff != $past(upd_ff)) |-> (upd_ff == $past(upd_ff) + 32'd1 || upd_ff == 32'd0))
      else $error("update count moved by other than one or a clear");

endmodule

FILE: tb/rpe_checker.sv
`timescale 1ns / 1ps

module rpe_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [rpe_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   input  logic                           req_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [rpe_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tuser,
   input  logic                           rsp_tlast,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [rpe_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rpe_pkg::CSR_DATA_W-1:0] csr_data,
   output int                             fail_count,
   output int                             params_waiting,
   output int                             params_seen,
   output int                             rejects_seen
);
   import rpe_pkg::*;

   typedef struct packed {
      logic [2:0]   index;
      logic [31:0]  value;
      logic [31:0]  pred;
      logic [31:0]  err;
      logic         status;
      logic [31:0]  total;
      logic         last;
   } param_word_type;

   param_word_type param_q[$];

   logic [3:0]  cfg_active;
   logic [30:0] cfg_init_cov;
   logic [16:0] cfg_lambda;
   logic [30:0] cfg_min_den;

   logic signed [31:0] theta[8];
   logic signed [31:0] cov[8][8];
   logic signed [31:0] elem_store[8];
   int unsigned        elem_count;
   logic [31:0]        applied;

   function automatic int n_used();
      int n;
      n = cfg_active;
      if (n < 1) n = 1;
      if (n > 8) n = 8;
      return n;
   endfunction

   // product scaled down by 2^16, rounded toward minus infinity
   function automatic longint mulq(input logic signed [31:0] a, input logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> 16;
   endfunction

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   task automatic clear_estimator();
      int n;
      n = n_used();
      for (int i = 0; i < 8; i++) begin
         theta[i] = 0;
         elem_store[i] = 0;
         for (int j = 0; j < 8; j++) cov[i][j] = 0;
      end
      for (int i = 0; i < n; i++) cov[i][i] = {1'b0, cfg_init_cov};
      elem_count = 0;
      applied = 0;
   endtask

   task automatic predict_update(input logic signed [31:0] meas);
      int n;
      logic signed [31:0] phi[8], pphi[8], phip[8], gain[8];
      logic signed [31:0] pred, err, den;
      longint acc, lambda, minden, absden, d;
      logic rejected;
      param_word_type w;
      n = n_used();
      for (int r = 0; r < 8; r++) phi[r] = (r < elem_count) ? elem_store[r] : 0;
      lambda = cfg_lambda;
      if (lambda < 1) lambda = 1;
      if (lambda > 65536) lambda = 65536;
      minden = cfg_min_den;
      if (minden < 1) minden = 1;
      acc = 0;
      for (int r = 0; r < n; r++) acc += mulq(theta[r], phi[r]);
      pred = clip32(acc);
      err = clip32(longint'(meas) - longint'(pred));
      for (int r = 0; r < n; r++) begin
         acc = 0;
         for (int c = 0; c < n; c++) acc += mulq(cov[r][c], phi[c]);
         pphi[r] = clip32(acc);
      end
      acc = lambda;
      for (int r = 0; r < n; r++) acc += mulq(phi[r], pphi[r]);
      den = clip32(acc);
      absden = (den < 0) ? -longint'(den) : longint'(den);
      rejected = absden < minden;
      if (!rejected) begin
         for (int r = 0; r < n; r++) begin
            gain[r] = clip32((longint'(pphi[r]) * 65536) / longint'(den));
            theta[r] = clip32(longint'(theta[r]) + mulq(gain[r], err));
         end
         for (int c = 0; c < n; c++) begin
            acc = 0;
            for (int r = 0; r < n; r++) acc += mulq(phi[r], cov[r][c]);
            phip[c] = clip32(acc);
         end
         for (int r = 0; r < n; r++) begin
            for (int c = 0; c < n; c++) begin
               d = clip32(longint'(cov[r][c]) - mulq(gain[r], phip[c]));
               cov[r][c] = clip32((d * 65536) / lambda);
            end
         end
         applied = applied + 1;
      end
      for (int r = 0; r < n; r++) begin
         w.index  = r[2:0];
         w.value  = theta[r];
         w.pred   = pred;
         w.err    = err;
         w.status = rejected ? STATUS_REJECTED : STATUS_APPLIED;
         w.total  = applied;
         w.last   = (r == n - 1);
         param_q.push_back(w);
      end
      for (int r = 0; r < 8; r++) elem_store[r] = 0;
      elem_count = 0;
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      param_word_type w;
      if (reset) begin
         cfg_active   = 4'd8;
         cfg_init_cov = 31'd6553600;
         cfg_lambda   = 17'd65536;
         cfg_min_den  = 31'd1;
         clear_estimator();
         param_q.delete();
      end else begin
         // compare the outgoing word with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (param_q.size() == 0) begin
               report_mismatch("unexpected word, index", rsp_tdata[2:0], 0);
            end else begin
               w = param_q.pop_front();
               params_seen++;
               if (w.status == STATUS_REJECTED && w.last) rejects_seen++;
               if (rsp_tdata[2:0] !== w.index)
                  report_mismatch("param_index", rsp_tdata[2:0], w.index);
               if (rsp_tdata[34:3] !== w.value)
                  report_mismatch("param_value", rsp_tdata[34:3], w.value);
               if (rsp_tdata[66:35] !== w.pred)
                  report_mismatch("prediction", rsp_tdata[66:35], w.pred);
               if (rsp_tdata[98:67] !== w.err)
                  report_mismatch("pred_error", rsp_tdata[98:67], w.err);
               if (rsp_tdata[130:99] !== w.total)
                  report_mismatch("update_total", rsp_tdata[130:99], w.total);
               if (rsp_tuser !== w.status) report_mismatch("status", rsp_tuser, w.status);
               if (rsp_tlast !== w.last) report_mismatch("last_result", rsp_tlast, w.last);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ACTIVE_PARAMS: cfg_active   = csr_data[3:0];
               REG_INITIAL_COV:   cfg_init_cov = csr_data[30:0];
               REG_FORGETTING:    cfg_lambda   = csr_data[16:0];
               REG_MIN_DEN:       cfg_min_den  = csr_data[30:0];
               default: ;
            endcase
            if (csr_index inside {REG_ACTIVE_PARAMS, REG_INITIAL_COV, REG_FORGETTING, REG_MIN_DEN})
               clear_estimator();
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == KIND_RESET) begin
               clear_estimator();
            end else begin
               if (elem_count < n_used()) begin
                  elem_store[elem_count] = req_tdata[31:0];
                  elem_count++;
               end
               if (req_tlast) predict_update(req_tdata[63:32]);
            end
         end
      end
      params_waiting = param_q.size();
   end

   initial begin
      fail_count = 0;
      params_waiting = 0;
      params_seen = 0;
      rejects_seen = 0;
   end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rpe_pkg::*;

   localparam int IDLE_LIMIT   = 60000;  // cycles without any accepted word
   localparam int HOLD_CYCLES  = 6000;   // long receiver hold-off
   localparam int TARGET_WORDS = 430;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic                    req_tuser = KIND_ELEMENT;
   logic                    req_tlast = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;
   logic                    rsp_tlast;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   int fail_count, params_waiting, params_seen, rejects_seen;
   int words_sent = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   bit hold_request = 1'b0;

   always #1 clock = ~clock;

   rls_parameter_estimator_core u_top (.*);

   rpe_checker u_checker (.*);

   // receiver: switch stall pattern now and then; honor a long hold-off request
   initial begin
      int mode, left;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(20, 300);
            end
            left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               2: rsp_tready <= ($urandom_range(0, 4) == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
            $display("FAILURE");
            $finish;
         end
      end
   end

   // drive one word; bursts of random length with random gaps between them
   task automatic send_word(input logic kind, input logic [31:0] value,
                            input logic [31:0] meas, input logic last);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {meas, value};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 2) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic drop_valid();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // pause until every expected parameter word has come out
   task automatic drain();
      drop_valid();
      while (params_waiting != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [31:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input int n, input logic [31:0] init_cov,
                             input logic [31:0] lambda, input logic [31:0] min_den);
      write_reg(REG_ACTIVE_PARAMS, n);
      write_reg(REG_INITIAL_COV, init_cov);
      write_reg(REG_FORGETTING, lambda);
      write_reg(REG_MIN_DEN, min_den);
   endtask

   // mostly modest magnitudes so the estimate converges; some full-range words
   function automatic logic [31:0] rand_q();
      case ($urandom_range(0, 9))
         0, 1:    return $urandom;
         2, 3, 4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
         default: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      endcase
   endfunction

   // one regressor run of random length ending in the last mark; some noise
   task automatic send_run(input int n);
      int len;
      len = $urandom_range(1, n + 2);
      if ($urandom_range(0, 19) == 0) begin
         send_word(KIND_RESET, $urandom, $urandom, 1'($urandom_range(0, 1)));
      end
      for (int i = 0; i < len; i++) begin
         send_word(KIND_ELEMENT, rand_q(), rand_q(), i == len - 1);
      end
   endtask

   task automatic random_phase(input int n, input int words);
      int stop;
      stop = words_sent + words;
      while (words_sent < stop) send_run(n);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: defaults, n = 8
      send_word(KIND_RESET, 32'h0, 32'h0, 1'b0);
      for (int i = 0; i < 8; i++) send_word(KIND_ELEMENT, 32'h0001_0000 << i[1:0], 32'h0003_0000,
                                            i == 7);
      for (int i = 0; i < 8; i++) send_word(KIND_ELEMENT, (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000,
                                            (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF, i == 7);
      // extra elements beyond n, then a short run with missing elements
      for (int i = 0; i < 10; i++) send_word(KIND_ELEMENT, 32'hFFFF_0000, 32'hFFFF_FFFF, i == 9);
      send_word(KIND_ELEMENT, 32'h0002_0000, 32'h0001_0000, 1'b1);

      // extremes: smallest n, covariance, lambda; huge threshold forces a reject
      set_config(1, 1, 1, 32'h7FFF_FFFF);
      send_word(KIND_ELEMENT, 32'h0001_0000, 32'h0005_0000, 1'b1);
      // out-of-range register values, upper bits set
      set_config(32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFE_0000, 32'h8000_0000);
      send_word(KIND_ELEMENT, 32'h0000_8000, 32'h0001_0000, 1'b1);
      set_config(15, 32'h7FFF_FFFF, 32'h0001_FFFF, 0);
      send_word(KIND_ELEMENT, 32'h0000_0000, 32'h0000_0000, 1'b1);
      write_reg(3'd5, $urandom);
      send_word(KIND_ELEMENT, 32'h0001_0000, 32'h0002_0000, 1'b1);

      // random phases across settings
      set_config(2, 32'h0064_0000, 32'h0000_F000, 1);
      hold_request = 1'b1;      // receiver holds off while runs keep coming
      random_phase(2, 60);
      set_config(3, 32'h0010_0000, 32'h0000_FD70, 32'h0000_0100);
      random_phase(3, 70);
      drain();
      set_config(1, 32'h0000_4000, 32'h0001_0000, 1);
      random_phase(1, 50);
      set_config(4, 32'h0064_0000, 32'h0000_FF00, 1);
      random_phase(4, 80);
      set_config(2, 32'h7FFF_FFFF, 32'h0000_8000, 32'h0100_0000);
      random_phase(2, 40);
      set_config(8, $urandom_range(1, 32'h00FF_FFFF), $urandom_range(1, 65536),
                 $urandom_range(1, 32'h0001_0000));
      random_phase(8, 25);
      set_config($urandom_range(1, 5), $urandom_range(1, 32'h7FFF_FFFF),
                 $urandom_range(1, 65536), $urandom_range(1, 32'h0000_FFFF));
      while (words_sent < TARGET_WORDS) send_run(5);

      drain();
      repeat (200) @(posedge clock);
      $display("run covered %0d input words, %0d parameter words, %0d rejected updates",
               words_sent, params_seen, rejects_seen);
      $display("settings swept: n from 1 to 8 plus out-of-range, lambda and thresholds at edges");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: rls_parameter_estimator_core.f
design/rpe_pkg.sv
design/rpe_divider.sv
design/rls_parameter_estimator_core.sv
tb/rpe_checker.sv
tb/tb_top.sv
